[src/swhc_pkg.sv]
// Shared types, constants and the sequencer microcode for the hit counter.
package swhc_pkg;

    localparam int          WIN_BITS     = 9;
    localparam int          CNT_BITS     = 32;
    localparam logic [8:0]  WINDOW_RESET = 9'd300;

    // Item opcodes.
    typedef enum logic {
        OP_HIT   = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // Microprogram step addresses.
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_INIT,
        S_UP_PROBE,
        S_UP_CMP,
        S_UP_DONE,
        S_LO_PROBE,
        S_LO_CMP,
        S_FIN
    } t_step;

    // Jump conditions.
    typedef enum logic [1:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_QUERY,
        C_DONE
    } t_cond;

    typedef struct packed {
        logic  busy;
        logic  hit_en;
        logic  init_up;
        logic  init_lo;
        logic  probe;
        logic  update;
        logic  emit;
        t_cond cond;
        t_step target;
    } t_ctrl;

    typedef struct packed {
        logic no_query;
        logic done;
    } t_flags;

    // Control store: one word per step.
    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w        = '0;
        w.cond   = C_NEXT;
        w.target = S_IDLE;
        unique case (step)
            S_IDLE: begin
                w.hit_en = 1'b1;
                w.cond   = C_NO_QUERY;
                w.target = S_IDLE;
            end
            S_UP_INIT: begin
                w.busy    = 1'b1;
                w.init_up = 1'b1;
            end
            S_UP_PROBE: begin
                w.busy   = 1'b1;
                w.probe  = 1'b1;
                w.cond   = C_DONE;
                w.target = S_UP_DONE;
            end
            S_UP_CMP: begin
                w.busy   = 1'b1;
                w.update = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = S_UP_PROBE;
            end
            S_UP_DONE: begin
                w.busy    = 1'b1;
                w.init_lo = 1'b1;
            end
            S_LO_PROBE: begin
                w.busy   = 1'b1;
                w.probe  = 1'b1;
                w.cond   = C_DONE;
                w.target = S_FIN;
            end
            S_LO_CMP: begin
                w.busy   = 1'b1;
                w.update = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = S_LO_PROBE;
            end
            S_FIN: begin
                w.busy   = 1'b1;
                w.emit   = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[src/swhc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module swhc_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[src/swhc_seq.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module swhc_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swhc_pkg::t_flags      i_flags,
    output swhc_pkg::t_ctrl       o_ctrl
);

    swhc_pkg::t_step r_pc;
    swhc_pkg::t_step n_pc;
    logic            take;

    always_comb begin
        o_ctrl = swhc_pkg::ucode(r_pc);
    end

    always_comb begin
        unique case (o_ctrl.cond)
            swhc_pkg::C_NEXT:     take = 1'b0;
            swhc_pkg::C_ALWAYS:   take = 1'b1;
            swhc_pkg::C_NO_QUERY: take = i_flags.no_query;
            swhc_pkg::C_DONE:     take = i_flags.done;
            default:              take = 1'b1;
        endcase
        if (take) begin
            n_pc = o_ctrl.target;
        end else begin
            n_pc = swhc_pkg::t_step'(r_pc + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= swhc_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[src/sliding_window_hit_counter.sv]
// Top level of the sliding-window hit counter: ring store, search datapath, ports.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+-------------------------------
//  item in  | start & !busy                   | i_op, i_timestamp
//  result   | o_strobe (one cycle, no stall)  | o_hit_count
//  config   | i_cfg_valid & o_cfg_ready       | i_window_seconds
//
// A hit item is absorbed in its accept cycle; busy stays low and the next item
// may follow at once. A query item holds busy through an init step before each
// of an upper and a lower binary search and a final emit step; each search makes
// up to ceil(log2(held+1)) probes (10 for a full 512-entry ring); the single read
// port gives each probe an address and a compare step. o_strobe rises at the edge
// at which busy falls, so the result shows in the first idle cycle. Synchronous
// active-low reset clears the ring pointers, the total and the sequencer and
// loads the window with 300; ring contents are not cleared, since only held
// entries are ever read.
// The receiver cannot stall; config is taken only while the sequencer is idle.
module sliding_window_hit_counter #(
    parameter int RING_DEPTH = 512,
    parameter int TIME_BITS  = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [TIME_BITS-1:0]          i_timestamp,
    output logic                          o_strobe,
    output logic [swhc_pkg::CNT_BITS-1:0] o_hit_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [swhc_pkg::WIN_BITS-1:0] i_window_seconds
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int DW = TIME_BITS + swhc_pkg::CNT_BITS;
    localparam int EW = TIME_BITS + swhc_pkg::WIN_BITS;

    // Ring slot of the k-th held entry, counted from the oldest.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] k);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(k);
        if (sum >= SW'(RING_DEPTH)) begin
            sum = sum - SW'(RING_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    swhc_pkg::t_ctrl  ctrl;
    swhc_pkg::t_flags flags;

    // Ring bookkeeping.
    logic [AW-1:0]                  r_oldest;
    logic [CW-1:0]                  r_held;
    logic [swhc_pkg::CNT_BITS-1:0]  r_total;
    logic [TIME_BITS-1:0]           r_newest_time;
    logic [swhc_pkg::WIN_BITS-1:0]  r_window;

    // Search datapath.
    logic [TIME_BITS-1:0]           r_t;
    logic [TIME_BITS-1:0]           r_key;
    logic [CW-1:0]                  r_lo;
    logic [CW-1:0]                  r_hi;
    logic [CW-1:0]                  r_mid;
    logic [swhc_pkg::CNT_BITS-1:0]  r_cand;
    logic [swhc_pkg::CNT_BITS-1:0]  r_upper;
    logic                           r_strobe;
    logic [swhc_pkg::CNT_BITS-1:0]  r_count;

    logic                           accept;
    logic                           hit;
    logic                           same_slot;
    logic                           full;
    logic [CW-1:0]                  n_mid;
    logic [EW-1:0]                  t_ext;
    logic [EW-1:0]                  w_ext;
    logic                           lower_ok;
    logic [EW-1:0]                  lower_diff;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [DW-1:0]                  ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [DW-1:0]                  ram_rdata;
    logic [TIME_BITS-1:0]           rd_time;
    logic [swhc_pkg::CNT_BITS-1:0]  rd_cum;

    swhc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    swhc_ram #(
        .WIDTH (DW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy        = ctrl.busy;
    assign o_cfg_ready = !ctrl.busy;
    assign o_strobe    = r_strobe;
    assign o_hit_count = r_count;

    assign accept = start && !busy;
    assign hit    = accept && ctrl.hit_en && (i_op == swhc_pkg::OP_HIT);

    // Sequencer flags: stay idle unless a query arrives; search ends when lo meets hi.
    assign flags.no_query = !(start && (i_op == swhc_pkg::OP_QUERY));
    assign flags.done     = (r_lo >= r_hi);

    assign rd_time = ram_rdata[DW-1 -: TIME_BITS];
    assign rd_cum  = ram_rdata[swhc_pkg::CNT_BITS-1:0];

    // Lower bound of the window; absent when t < window.
    assign t_ext      = EW'(r_t);
    assign w_ext      = EW'(r_window);
    assign lower_ok   = (t_ext >= w_ext);
    assign lower_diff = t_ext - w_ext;

    // Probe midpoint.
    assign n_mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign ram_raddr = slot_of(r_oldest, n_mid);

    // Hit path: fold into the newest entry when not later, else append.
    assign same_slot = (r_held != '0) && (i_timestamp <= r_newest_time);
    assign full      = (r_held == CW'(RING_DEPTH));

    always_comb begin
        ram_we    = hit;
        ram_wdata = {same_slot ? r_newest_time : i_timestamp,
                     r_total + swhc_pkg::CNT_BITS'(1)};
        if (same_slot) begin
            ram_waddr = slot_of(r_oldest, r_held - CW'(1));
        end else if (full) begin
            ram_waddr = r_oldest;
        end else begin
            ram_waddr = slot_of(r_oldest, r_held);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_held   <= '0;
            r_total  <= '0;
            r_window <= swhc_pkg::WINDOW_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= ctrl.emit;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_window_seconds;
            end
            if (hit) begin
                r_total <= r_total + swhc_pkg::CNT_BITS'(1);
                if (!same_slot) begin
                    if (full) begin
                        // drop the oldest entry, count stays at depth
                        r_oldest <= slot_of(r_oldest, CW'(1));
                    end else begin
                        r_held <= r_held + CW'(1);
                    end
                end
            end
        end
    end

    // Payload and search registers.
    always_ff @(posedge i_clk) begin
        if (hit && !same_slot) begin
            r_newest_time <= i_timestamp;
        end
        if (accept) begin
            r_t <= i_timestamp;
        end
        if (ctrl.init_up) begin
            r_key  <= r_t;
            r_lo   <= '0;
            r_hi   <= r_held;
            r_cand <= '0;
        end
        if (ctrl.init_lo) begin
            // hold the upper result, search again at t - window
            r_upper <= r_cand;
            r_key   <= lower_diff[TIME_BITS-1:0];
            r_lo    <= '0;
            r_hi    <= lower_ok ? r_held : '0;
            r_cand  <= '0;
        end
        if (ctrl.probe) begin
            r_mid <= n_mid;
        end
        if (ctrl.update) begin
            if (rd_time <= r_key) begin
                r_lo   <= r_mid + CW'(1);
                r_cand <= rd_cum;
            end else begin
                r_hi <= r_mid;
            end
        end
        if (ctrl.emit) begin
            r_count <= r_upper - r_cand;
        end
    end

    // The result strobe lasts exactly one cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_strobe |=> !r_strobe)
        else $error("result strobe held longer than one cycle");

    // A hit never occupies the block.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == swhc_pkg::OP_HIT)) |=> !busy)
        else $error("hit item left the block busy");

    // A query always starts the search program.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == swhc_pkg::OP_QUERY)) |=> busy)
        else $error("query item did not start a search");

    // The ring never holds more entries than it has slots.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(RING_DEPTH))
        else $error("ring entry count exceeds depth");

    // Each result follows the last step of a query program.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(ctrl.emit))
        else $error("result strobe without a finished query");

endmodule

[tb/swhc_checker.sv]
// Scoreboard for the hit counter: window-count predictor and result checks.
`timescale 1ns / 100ps

module swhc_checker #(
    parameter int RING_DEPTH = 512,
    parameter int TIME_BITS  = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_op,
    input  logic [TIME_BITS-1:0]          i_timestamp,
    input  logic                          i_strobe,
    input  logic [swhc_pkg::CNT_BITS-1:0] i_hit_count,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [swhc_pkg::WIN_BITS-1:0] i_window_seconds,
    output int                            o_fail_count,
    output int                            o_pending
);

    logic [TIME_BITS-1:0]          stamp_ring   [RING_DEPTH];
    logic [swhc_pkg::CNT_BITS-1:0] running_ring [RING_DEPTH];
    int unsigned                   oldest;
    int unsigned                   held;
    logic [swhc_pkg::CNT_BITS-1:0] hit_total;
    logic [swhc_pkg::WIN_BITS-1:0] window_len;
    logic [swhc_pkg::CNT_BITS-1:0] expected_counts [$];
    logic [swhc_pkg::CNT_BITS-1:0] want;

    function automatic int unsigned ring_slot(input int unsigned k);
        return (oldest + k) % RING_DEPTH;
    endfunction

    // Running total at the latest held entry not after limit, 0 if none.
    function automatic logic [swhc_pkg::CNT_BITS-1:0] total_through(
        input logic [TIME_BITS-1:0] limit);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = held;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (stamp_ring[ring_slot(mid)] <= limit)
                lo = mid + 1;
            else
                hi = mid;
        end
        return (lo == 0) ? '0 : running_ring[ring_slot(lo - 1)];
    endfunction

    function automatic void record_hit(input logic [TIME_BITS-1:0] ts);
        int unsigned slot;
        hit_total = hit_total + 1'b1;
        // Late or repeated time: fold into the newest entry.
        if (held > 0 && ts <= stamp_ring[ring_slot(held - 1)]) begin
            running_ring[ring_slot(held - 1)] = hit_total;
            return;
        end
        if (held >= RING_DEPTH) begin
            oldest = (oldest + 1) % RING_DEPTH;
            held   = RING_DEPTH - 1;
        end
        slot               = ring_slot(held);
        stamp_ring[slot]   = ts;
        running_ring[slot] = hit_total;
        held               = held + 1;
    endfunction

    function automatic logic [swhc_pkg::CNT_BITS-1:0] window_count(
        input logic [TIME_BITS-1:0] ts);
        logic [swhc_pkg::CNT_BITS-1:0] upper;
        logic [swhc_pkg::CNT_BITS-1:0] lower;
        upper = total_through(ts);
        lower = '0;
        if (ts >= window_len)
            lower = total_through(ts - window_len);
        return upper - lower;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            oldest       = 0;
            held         = 0;
            hit_total    = '0;
            window_len   = swhc_pkg::WINDOW_RESET;
            o_fail_count = 0;
            expected_counts.delete();
        end else begin
            // Retire the result first: a new query may be taken on the same edge.
            if (i_strobe) begin
                if (expected_counts.size() == 0) begin
                    $error("hit_count: no result expected, actual %0d", i_hit_count);
                    o_fail_count++;
                end else begin
                    want = expected_counts.pop_front();
                    if (i_hit_count !== want) begin
                        $error("hit_count mismatch: expected %0d, actual %0d",
                               want, i_hit_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                window_len = i_window_seconds;
            if (i_start && !i_busy) begin
                if (i_op == swhc_pkg::OP_QUERY)
                    expected_counts.push_back(window_count(i_timestamp));
                else
                    record_hit(i_timestamp);
            end
        end
        o_pending = expected_counts.size();
    end

endmodule

[tb/sliding_window_hit_counter_tb.sv]
// Testbench top for the hit counter: clock, reset, item stimulus and the verdict.
`timescale 1ns / 100ps

module sliding_window_hit_counter_tb;

    localparam int                   RING_DEPTH = 512;
    localparam int                   TIME_BITS  = 31;
    localparam logic [TIME_BITS-1:0] TS_MAX     = '1;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic                          i_op;
    logic [TIME_BITS-1:0]          i_timestamp;
    logic                          o_strobe;
    logic [swhc_pkg::CNT_BITS-1:0] o_hit_count;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [swhc_pkg::WIN_BITS-1:0] i_window_seconds;

    int                   fail_count;
    int                   pending;
    int                   drain;
    longint               newest_ts;   // time of the newest in-order hit
    int                   window_now;  // window the block currently holds

    sliding_window_hit_counter #(
        .RING_DEPTH(RING_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_timestamp     (i_timestamp),
        .o_strobe        (o_strobe),
        .o_hit_count     (o_hit_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_window_seconds(i_window_seconds)
    );

    swhc_checker #(
        .RING_DEPTH(RING_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) scoreboard (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_op            (i_op),
        .i_timestamp     (i_timestamp),
        .i_strobe        (o_strobe),
        .i_hit_count     (o_hit_count),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_window_seconds(i_window_seconds),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Drop start and keep the channel quiet; n sets how long it stays quiet.
    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Present one item and hold it until the block takes it. Start is left
    // high on return so a back-to-back item needs no fresh rise on it.
    task automatic send_item(input swhc_pkg::t_op op, input longint ts);
        start       <= 1'b1;
        i_op        <= op;
        i_timestamp <= ts[TIME_BITS-1:0];
        do begin
            @(posedge i_clk);
        end while (busy);
        @(negedge i_clk);
    endtask

    // Wait until every query answer is back, then let the clock run on before
    // returning (hits leave nothing to wait on).
    task automatic settle();
        start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_window(input int value);
        settle();
        i_cfg_valid      <= 1'b1;
        i_window_seconds <= value[swhc_pkg::WIN_BITS-1:0];
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        window_now = value;
    endtask

    function automatic longint clamp_ts(input longint ts);
        if (ts < 1)
            return 1;
        if (ts > longint'(TS_MAX))
            return longint'(TS_MAX);
        return ts;
    endfunction

    // Random traffic: mostly in-order hits that keep the ring growing past
    // its depth, queries around the newest time with the window straddling
    // the stored history, and some late hits and far-back queries as noise.
    task automatic run_random(input int count, input int idle_pct);
        int     r;
        longint qt;
        for (int i = 0; i < count; i++) begin
            while ($urandom_range(99) < idle_pct)
                hold_off(1);
            r = $urandom_range(99);
            if (r < 68) begin
                if ($urandom_range(99) < 5) begin
                    // Late hit: lands on the newest entry.
                    send_item(swhc_pkg::OP_HIT,
                              clamp_ts(newest_ts - $urandom_range(50, 1)));
                end else begin
                    if ($urandom_range(9) != 0)
                        newest_ts = newest_ts + $urandom_range(4, 1);
                    send_item(swhc_pkg::OP_HIT, newest_ts);
                end
            end else if (r < 94) begin
                qt = newest_ts + $urandom_range(6, 0) - $urandom_range(window_now + 6, 0);
                send_item(swhc_pkg::OP_QUERY, clamp_ts(qt));
                // Now and then let the block drain completely before going on.
                if ($urandom_range(99) < 3)
                    settle();
            end else begin
                qt = $urandom_range(32'(newest_ts), 1);
                send_item(swhc_pkg::OP_QUERY, qt);
            end
        end
    endtask

    initial begin
        start            = 1'b0;
        i_op             = 1'b0;
        i_timestamp      = '0;
        i_cfg_valid      = 1'b0;
        i_window_seconds = swhc_pkg::WINDOW_RESET;
        i_rst_n          = 1'b0;
        window_now       = int'(swhc_pkg::WINDOW_RESET);
        newest_ts        = 1;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset window of 300.
        send_item(swhc_pkg::OP_QUERY, 1);      // empty ring
        send_item(swhc_pkg::OP_HIT, 1);
        send_item(swhc_pkg::OP_HIT, 1);        // same time: update newest entry
        send_item(swhc_pkg::OP_HIT, 5);
        send_item(swhc_pkg::OP_HIT, 3);        // late hit, folded into time 5
        send_item(swhc_pkg::OP_QUERY, 5);
        send_item(swhc_pkg::OP_QUERY, 2);      // query earlier than the window length
        send_item(swhc_pkg::OP_HIT, 400);
        send_item(swhc_pkg::OP_HIT, 650);
        send_item(swhc_pkg::OP_QUERY, 650);    // lower bound falls between entries
        send_item(swhc_pkg::OP_QUERY, 400);
        send_item(swhc_pkg::OP_QUERY, 700);    // lower bound lands on an entry
        send_item(swhc_pkg::OP_QUERY, 200);    // query behind the newest entry
        send_item(swhc_pkg::OP_QUERY, 100000); // far past all history

        // Zero window always answers 0.
        write_window(0);
        send_item(swhc_pkg::OP_QUERY, 650);
        send_item(swhc_pkg::OP_QUERY, 5);

        // Narrowest non-zero window.
        write_window(1);
        send_item(swhc_pkg::OP_HIT, 651);
        send_item(swhc_pkg::OP_QUERY, 651);
        send_item(swhc_pkg::OP_QUERY, 652);

        // Widest window.
        write_window(511);
        send_item(swhc_pkg::OP_QUERY, 651);
        newest_ts = 651;

        // Phase 1: narrow window, sender idles about 30 percent.
        write_window(1);
        newest_ts = newest_ts + $urandom_range(32'd1 << 28, 32'd1 << 20);
        run_random(310, 30);

        // Phase 2: widest window, sender idles about 63 percent.
        write_window(511);
        newest_ts = newest_ts + $urandom_range(32'd1 << 28, 32'd1 << 20);
        run_random(310, 63);

        // Phase 3: random window, items back to back.
        write_window($urandom_range(510, 2));
        newest_ts = newest_ts + $urandom_range(32'd1 << 28, 32'd1 << 20);
        run_random(310, 0);

        // Top of the time range.
        send_item(swhc_pkg::OP_HIT, TS_MAX);
        send_item(swhc_pkg::OP_HIT, TS_MAX);
        send_item(swhc_pkg::OP_QUERY, TS_MAX);
        send_item(swhc_pkg::OP_QUERY, longint'(TS_MAX) - 600);

        // Drain outstanding answers, bounded, then let the block settle.
        start <= 1'b0;
        drain = 0;
        while (pending != 0 && drain < 5000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (50) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS sliding_window_hit_counter");
        else
            $display("FAIL sliding_window_hit_counter");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5ms;
        $display("FAIL sliding_window_hit_counter");
        $finish;
    end

endmodule
